// ===== hw/rtl/tcm_pkg.sv =====
// Shared constants and types of the texel converter with mip cascade.
package tcm_pkg;

  localparam int MAX_SIZE_LOG2   = 8;
  localparam int PALETTE_ENTRIES = 256;
  localparam int NUM_CELLS       = MAX_SIZE_LOG2 + 1;
  localparam int PAL_AW          = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int PAIR_AW         = (MAX_SIZE_LOG2 > 1) ? MAX_SIZE_LOG2 - 1 : 1;

  localparam logic [1:0] MODE_KEYED  = 2'd0;
  localparam logic [1:0] MODE_ALPHA  = 2'd1;
  localparam logic [1:0] MODE_DIRECT = 2'd2;
  // The spare code behaves as direct mode.
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  localparam logic [1:0] REG_SOURCE_MODE     = 2'd0;
  localparam logic [1:0] REG_SIZE_LOG2       = 2'd1;
  localparam logic [1:0] REG_GENERATE_LEVELS = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [31:0] word;
    logic [7:0]  row;
    logic [7:0]  col;
    logic        last_texel;
  } tok_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  level;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] word;
    logic        last_run;
    logic        done;
  } res_t;

endpackage

// ===== hw/rtl/tcm_convert.sv =====
// Palette store and conversion of one source texel to an RGBA word.
module tcm_convert (
  input  logic              clk,
  input  logic              rst,
  input  logic              pal_wr,
  input  logic              texel_in,
  input  logic [7:0]        index_byte,
  input  logic [7:0]        alpha_byte,
  input  logic [31:0]       color_word,
  input  logic [1:0]        source_mode,
  input  logic [7:0]        row,
  input  logic [7:0]        col,
  input  logic              last_texel,
  output tcm_pkg::tok_t     tok
);
  import tcm_pkg::*;

  logic [23:0] palette [PALETTE_ENTRIES];
  logic [23:0] pal_q;
  logic        in_range;
  logic        in_range_q;
  logic        pending;
  logic [7:0]  alpha_q;
  logic [31:0] color_q;
  logic [7:0]  row_q;
  logic [7:0]  col_q;
  logic        last_q;
  logic [31:0] pal_word;

  assign in_range = {1'b0, index_byte} < 9'(PALETTE_ENTRIES);

  always_ff @(posedge clk) begin
    if (pal_wr && in_range) begin
      palette[index_byte[PAL_AW-1:0]] <= color_word[23:0];
    end
    if (texel_in) begin
      pal_q      <= palette[index_byte[PAL_AW-1:0]];
      in_range_q <= in_range;
      alpha_q    <= alpha_byte;
      color_q    <= color_word;
      row_q      <= row;
      col_q      <= col;
      last_q     <= last_texel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= texel_in;
    end
  end

  assign pal_word = in_range_q ? {8'h00, pal_q} : 32'h0;

  always_comb begin
    tok.valid      = pending;
    tok.row        = row_q;
    tok.col        = col_q;
    tok.last_texel = last_q;
    case (source_mode)
      MODE_KEYED: tok.word = (pal_word != 32'h0) ? (pal_word | 32'hff000000) : 32'h0;
      MODE_ALPHA: tok.word = {alpha_q, pal_word[23:0]};
      default:    tok.word = (color_q & 32'hff00ff00) | {24'h0, color_q[23:16]}
                             | {8'h0, color_q[7:0], 16'h0};
    endcase
  end

endmodule

// ===== hw/rtl/tcm_cell.sv =====
// One mip level of the cascade: emits its texel and averages 2x2 blocks for the next level.
module tcm_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic [3:0]        level,
  input  logic [3:0]        size_n,
  input  logic              generate_levels,
  input  logic              advance,
  input  logic              rd_en,
  input  logic [7:0]        rd_col,
  input  tcm_pkg::tok_t     tok_in,
  output tcm_pkg::tok_t     tok_out,
  output tcm_pkg::res_t     res,
  output logic              busy
);
  import tcm_pkg::*;

  // Each entry holds an even-row column pair: odd column high, even column low.
  logic [63:0]  pairs [2**PAIR_AW];
  logic [63:0]  pair_q;
  tok_t         tok;
  logic [31:0]  even_left;
  logic [31:0]  odd_left;
  logic         active;
  logic         cont;
  logic         fire;
  logic [7:0]   rd_shift;
  logic [31:0]  box;

  assign active   = generate_levels && (level < size_n);
  assign cont     = active && tok.row[0] && tok.col[0];
  assign fire     = tok.valid && advance;
  assign rd_shift = 8'({1'b0, rd_col} >> ({1'b0, level} + 5'd1));
  assign busy     = tok.valid;

  always_comb begin
    logic [9:0] s;
    box = 32'h0;
    for (int b = 0; b < 4; b++) begin
      s = {2'b00, pair_q[8*b +: 8]} + {2'b00, pair_q[32 + 8*b +: 8]}
        + {2'b00, odd_left[8*b +: 8]} + {2'b00, tok.word[8*b +: 8]};
      box[8*b +: 8] = s[9:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pair_q <= pairs[rd_shift[PAIR_AW-1:0]];
    end
    if (fire && active && !tok.row[0] && tok.col[0]) begin
      pairs[tok.col[PAIR_AW:1]] <= {tok.word, even_left};
    end
    if (fire && active && !tok.col[0]) begin
      if (tok.row[0]) begin
        odd_left <= tok.word;
      end else begin
        even_left <= tok.word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else if (tok_in.valid) begin
      tok.valid <= 1'b1;
    end else if (fire) begin
      tok.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      tok.word       <= tok_in.word;
      tok.row        <= tok_in.row;
      tok.col        <= tok_in.col;
      tok.last_texel <= tok_in.last_texel;
    end
  end

  always_comb begin
    tok_out.valid      = fire && cont;
    tok_out.word       = box;
    tok_out.row        = tok.row >> 1;
    tok_out.col        = tok.col >> 1;
    tok_out.last_texel = tok.last_texel;
    res.valid          = tok.valid;
    res.level          = level;
    res.row            = tok.row;
    res.col            = tok.col;
    res.word           = tok.word;
    res.last_run       = !cont;
    res.done           = !cont && tok.last_texel;
  end

endmodule

// ===== hw/rtl/texel_convert_mipmap_cascade_top.sv =====
// Top level of the texel converter with mip-level cascade.
// Palette writes are taken one per cycle while the block is not busy with a texel,
// and give no result. A texel is taken, converted from the palette in the next
// cycle, and then walks down the row of level cells, one cell per cycle unless the
// output side stalls, each cell it reaches giving one result; the next texel is
// taken once the last cell has handed its result to the output register. Row pairs
// of each level are kept in a small memory inside that level's cell and are read
// when the texel is taken.
module texel_convert_mipmap_cascade_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // index_byte, alpha_byte, color_word
  input  logic [0:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // mip_level, texel_row, texel_col, rgba_word, zero fill
  output logic        m_tlast,   // last_of_run
  output logic [0:0]  m_tuser,   // image_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import tcm_pkg::*;

  logic [1:0]  source_mode;
  logic [3:0]  size_log2;
  logic        generate_levels;
  logic [7:0]  base_row;
  logic [7:0]  base_col;
  logic [3:0]  size_n;
  logic [8:0]  side;
  logic [7:0]  row;
  logic [7:0]  col;
  logic        last_texel;
  logic        s_fire;
  logic        texel_in;
  logic        pal_wr;
  logic        advance;
  logic        busy;
  tok_t        conv_tok;
  tok_t        tok_in  [NUM_CELLS];
  tok_t        tok_out [NUM_CELLS];
  res_t        res     [NUM_CELLS];
  logic [NUM_CELLS-1:0] cell_busy;
  res_t        sel;
  res_t        out_q;

  assign cfg_ready = 1'b1;
  assign size_n    = (size_log2 > 4'(MAX_SIZE_LOG2)) ? 4'(MAX_SIZE_LOG2) : size_log2;
  assign side      = 9'd1 << size_n;
  assign row       = ({1'b0, base_row} >= side) ? 8'd0 : base_row;
  assign col       = ({1'b0, base_col} >= side) ? 8'd0 : base_col;
  assign last_texel = ({1'b0, row} == side - 9'd1) && ({1'b0, col} == side - 9'd1);

  assign busy     = conv_tok.valid || (|cell_busy);
  assign s_tready = !busy;
  assign s_fire   = s_tvalid && s_tready;
  assign texel_in = s_fire && !s_tuser[0];
  assign pal_wr   = s_fire && s_tuser[0];
  assign advance  = !out_q.valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_mode     <= MODE_KEYED;
      size_log2       <= 4'd8;
      generate_levels <= 1'b1;
      base_row        <= 8'd0;
      base_col        <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SOURCE_MODE:     source_mode     <= cfg_data[1:0];
        REG_SIZE_LOG2:       size_log2       <= cfg_data;
        REG_GENERATE_LEVELS: generate_levels <= cfg_data[0];
        default: ;
      endcase
      if (cfg_index <= REG_GENERATE_LEVELS) begin
        base_row <= 8'd0;
        base_col <= 8'd0;
      end
    end else if (texel_in) begin
      if ({1'b0, col} + 9'd1 >= side) begin
        base_col <= 8'd0;
        base_row <= ({1'b0, row} + 9'd1 >= side) ? 8'd0 : row + 8'd1;
      end else begin
        base_col <= col + 8'd1;
        base_row <= row;
      end
    end
  end

  tcm_convert u_convert (
    .clk         (clk),
    .rst         (rst),
    .pal_wr      (pal_wr),
    .texel_in    (texel_in),
    .index_byte  (s_tdata[7:0]),
    .alpha_byte  (s_tdata[15:8]),
    .color_word  (s_tdata[47:16]),
    .source_mode (source_mode),
    .row         (row),
    .col         (col),
    .last_texel  (last_texel),
    .tok         (conv_tok)
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in[i] = conv_tok;
    end else begin : g_link
      assign tok_in[i] = tok_out[i-1];
    end
    tcm_cell u_cell (
      .clk             (clk),
      .rst             (rst),
      .level           (4'(i)),
      .size_n          (size_n),
      .generate_levels (generate_levels),
      .advance         (advance),
      .rd_en           (texel_in),
      .rd_col          (col),
      .tok_in          (tok_in[i]),
      .tok_out         (tok_out[i]),
      .res             (res[i]),
      .busy            (cell_busy[i])
    );
  end

  // At most one cell holds a texel, so an OR of the gated results selects it.
  always_comb begin
    sel = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (res[i].valid) begin
        sel = sel | res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_q.valid <= 1'b0;
    end else if (advance) begin
      out_q.valid <= sel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && sel.valid) begin
      out_q.level    <= sel.level;
      out_q.row      <= sel.row;
      out_q.col      <= sel.col;
      out_q.word     <= sel.word;
      out_q.last_run <= sel.last_run;
      out_q.done     <= sel.done;
    end
  end

  assign m_tvalid = out_q.valid;
  assign m_tdata  = {4'h0, out_q.word, out_q.col, out_q.row, out_q.level};
  assign m_tlast  = out_q.last_run;
  assign m_tuser  = out_q.done;

endmodule

// ===== hw/rtl/tcm_checker.sv =====
// Port-level checks of the texel converter, bound to the top level.
module tcm_props (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic        m_tlast,
  input logic [0:0]  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_texel_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser[0] |=> !s_tready)
    else $error("texel transfer not followed by busy");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("image end without end of run");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind texel_convert_mipmap_cascade_top tcm_props u_tcm_props (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// ===== tb/tcm_checker.sv =====
// Checker for the texel converter: tracks palette, config and level state, predicts, compares.
module tcm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic        m_tlast,
  input  logic [0:0]  m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcm_pkg::*;

  typedef struct packed {
    logic [3:0]  level;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] word;
    logic        last_run;
    logic        done;
  } texel_res_t;

  texel_res_t  texels_due[$];
  logic [1:0]  mode_q;
  logic [3:0]  size_q;
  logic        levels_q;
  logic [23:0] palette[PALETTE_ENTRIES];
  logic [31:0] row_pairs[2 << MAX_SIZE_LOG2];
  logic [31:0] left_texel[NUM_CELLS];
  logic [7:0]  pos_row, pos_col;

  assign pending = texels_due.size();

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic [31:0] box_average(input logic [31:0] a, b, c, d);
    logic [31:0] res;
    logic [9:0]  s;
    for (int sh = 0; sh < 32; sh += 8) begin
      s = {2'b00, a[sh+:8]} + {2'b00, b[sh+:8]} + {2'b00, c[sh+:8]} + {2'b00, d[sh+:8]};
      res[sh+:8] = s[9:2];
    end
    return res;
  endfunction

  task automatic predict_texel(input logic [7:0] idx, input logic [7:0] alpha,
                               input logic [31:0] word);
    int unsigned n, side, r, c, k, lvl, off, mask;
    logic [31:0] cur;
    texel_res_t  item;
    n = (size_q > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : size_q;
    side = 1 << n;
    mask = (2 << MAX_SIZE_LOG2) - 1;
    if (pos_row >= side) pos_row = 8'd0;
    if (pos_col >= side) pos_col = 8'd0;
    case (mode_q)
      MODE_KEYED: begin
        cur = {8'h00, palette[idx]};
        if (cur != 0) cur[31:24] = 8'hff;
      end
      MODE_ALPHA: cur = {alpha, palette[idx]};
      default:    cur = {word[31:24], word[7:0], word[15:8], word[23:16]};
    endcase
    r = pos_row; c = pos_col; k = n; lvl = 0;
    item = '{level: 4'd0, row: 8'(r), col: 8'(c), word: cur, last_run: 1'b0, done: 1'b0};
    texels_due.push_back(item);
    if (levels_q) begin
      while (k > 0) begin
        off = (2 << MAX_SIZE_LOG2) - (2 << k);
        if (r[0] == 0) begin
          row_pairs[(off + c) & mask] = cur;
          break;
        end
        if (c[0] == 0) begin
          left_texel[lvl] = cur;
          break;
        end
        cur = box_average(row_pairs[(off + c - 1) & mask], row_pairs[(off + c) & mask],
                          left_texel[lvl], cur);
        r >>= 1; c >>= 1; k--; lvl++;
        item = '{level: 4'(lvl), row: 8'(r), col: 8'(c), word: cur,
                 last_run: 1'b0, done: 1'b0};
        texels_due.push_back(item);
      end
    end
    texels_due[texels_due.size() - 1].last_run = 1;
    if (pos_row == side - 1 && pos_col == side - 1)
      texels_due[texels_due.size() - 1].done = 1;
    if (pos_col + 1 >= side) begin
      pos_col = 8'd0;
      pos_row = (pos_row + 1 >= side) ? 8'd0 : pos_row + 8'd1;
    end else begin
      pos_col++;
    end
  endtask

  always @(posedge clk) begin
    texel_res_t exp_r;
    if (rst) begin
      mode_q <= MODE_KEYED; size_q <= 4'd8; levels_q <= 1'b1;
      pos_row = 8'd0; pos_col = 8'd0;
      texels_due.delete();
      errors = 0; results_seen = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (texels_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_tdata));
        end else begin
          exp_r = texels_due.pop_front();
          if (m_tdata[3:0] !== exp_r.level)
            report_mismatch($sformatf("level %0d exp %0d", m_tdata[3:0], exp_r.level));
          if (m_tdata[11:4] !== exp_r.row)
            report_mismatch($sformatf("row %0d exp %0d", m_tdata[11:4], exp_r.row));
          if (m_tdata[19:12] !== exp_r.col)
            report_mismatch($sformatf("col %0d exp %0d", m_tdata[19:12], exp_r.col));
          if (m_tdata[51:20] !== exp_r.word)
            report_mismatch($sformatf("word %h exp %h", m_tdata[51:20], exp_r.word));
          if (m_tlast !== exp_r.last_run)
            report_mismatch($sformatf("last_of_run %b exp %b", m_tlast, exp_r.last_run));
          if (m_tuser[0] !== exp_r.done)
            report_mismatch($sformatf("image_done %b exp %b", m_tuser[0], exp_r.done));
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser[0]) palette[s_tdata[7:0]] = s_tdata[39:16];
        else predict_texel(s_tdata[7:0], s_tdata[15:8], s_tdata[47:16]);
      end
      // Any write to a defined register restarts the image.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SOURCE_MODE:     mode_q <= cfg_data[1:0];
          REG_SIZE_LOG2:       size_q <= cfg_data;
          REG_GENERATE_LEVELS: levels_q <= cfg_data[0];
          default: ;
        endcase
        if (cfg_index <= REG_GENERATE_LEVELS) begin
          pos_row = 8'd0; pos_col = 8'd0;
        end
      end
    end
  end
endmodule

// ===== tb/testbench.sv =====
// Stimulus and verdict for the texel converter with mip-level cascade.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tcm_pkg::*;

  logic        clk, rst;
  logic        s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
  logic [47:0] s_tdata;
  logic [0:0]  s_tuser, m_tuser;
  logic [55:0] m_tdata;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_data;
  int          errors, pending, results_seen;
  int          quiet_cycles, texels_sent;
  bit          calm, hold_off;
  logic [7:0]  written_slots[$];

  localparam int WATCHDOG = 20000;

  texel_convert_mipmap_cascade_top dut (.*);

  tcm_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    bit held;
    held = 0;
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_off && !held) begin
        held = 1;
        m_tready <= 0;
        repeat (300) @(negedge clk);
      end
      m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("[texel_convert_mipmap_cascade_top] ERROR");
      $finish;
    end
  end

  // The item stays offered after its transfer until the next send or drain replaces it.
  task automatic send(input logic req, input logic [7:0] idx, input logic [7:0] alpha,
                      input logic [31:0] word);
    if (!calm)
      while ($urandom_range(99) < 7) begin
        s_tvalid <= 0;
        @(negedge clk);
      end
    s_tvalid <= 1;
    s_tuser  <= req;
    s_tdata  <= {word, alpha, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (req) written_slots.push_back(idx);
    else texels_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    drain();
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [7:0] used_slot();
    return written_slots[$urandom_range(written_slots.size() - 1)];
  endfunction

  // A texel with random content, reading only palette slots already written.
  task automatic random_texel();
    send(1'b0, used_slot(), 8'($urandom), $urandom);
  endtask

  initial begin
    int lg;
    s_tvalid = 0; s_tdata = 0; s_tuser = 0;
    cfg_valid = 0; cfg_index = REG_SOURCE_MODE; cfg_data = 0;
    calm = 0; hold_off = 0; texels_sent = 0;
    rst = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: palette extremes including black, then each mode at small sizes.
    send(1'b1, 8'd0, 8'd0, 32'h0000_0000);
    send(1'b1, 8'd255, 8'hff, 32'hffff_ffff);
    send(1'b1, 8'd1, 8'd0, 32'hff12_3456);
    send(1'b1, 8'd2, 8'd0, 32'h00ab_cdef);
    write_reg(REG_SIZE_LOG2, 4'd1);
    send(1'b0, 8'd0, 8'hff, 32'h0);
    send(1'b0, 8'd255, 8'h00, 32'h0);
    send(1'b0, 8'd1, 8'h55, 32'h0);
    send(1'b0, 8'd2, 8'haa, 32'h0);
    write_reg(REG_SOURCE_MODE, 4'(MODE_ALPHA));
    for (int i = 0; i < 4; i++)
      send(1'b0, (i == 0) ? 8'd255 : 8'd0, (i != 0) ? 8'h00 : 8'hff, 32'h0);
    write_reg(REG_SOURCE_MODE, 4'(MODE_DIRECT));
    send(1'b0, 8'hff, 8'hff, 32'hffff_ffff);
    send(1'b0, 8'h00, 8'h00, 32'h0000_0000);
    send(1'b0, 8'h5a, 8'ha5, 32'h1234_5678);
    send(1'b0, 8'ha5, 8'h5a, 32'hedcb_a987);
    write_reg(REG_SOURCE_MODE, 4'(MODE_SPARE));
    write_reg(REG_SIZE_LOG2, 4'd0);
    send(1'b0, 8'd7, 8'd7, 32'hdead_beef);
    send(1'b0, 8'd7, 8'd7, 32'h0bad_f00d);
    write_reg(REG_SIZE_LOG2, 4'd15);
    write_reg(REG_GENERATE_LEVELS, 4'd0);
    send(1'b0, 8'd3, 8'd3, 32'h8001_7ffe);

    // Random phases: settings vary, at most ten texels of a small image, palette writes mixed in.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_SOURCE_MODE, 4'($urandom_range(3)));
      lg = (ph == 6) ? 2 :
           (($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(1, 2));
      write_reg(REG_SIZE_LOG2, 4'(lg));
      write_reg(REG_GENERATE_LEVELS, 4'((ph % 4) != 3));
      calm = (ph == 4);
      if (ph == 6) hold_off = 1;
      for (int i = 0; i < 2; i++)
        send(1'b1, 8'($urandom), 8'($urandom), $urandom);
      for (int i = 0; i < (1 << (2 * lg)) && i < 10; i++) begin
        if ($urandom_range(9) == 0) send(1'b1, 8'($urandom), 8'($urandom), $urandom);
        random_texel();
      end
      if (ph == 2) drain();
    end
    calm = 0;

    drain();
    $display("Covered %0d texels and %0d results over all modes, sizes 1 to 8 and 256,",
             texels_sent, results_seen);
    $display("level generation on and off, with random stalls and a long output hold-off.");
    if (errors == 0) begin
      $display("[texel_convert_mipmap_cascade_top] OK");
    end else begin
      $display("[texel_convert_mipmap_cascade_top] ERROR");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/tcm_pkg.sv
hw/rtl/tcm_convert.sv
hw/rtl/tcm_cell.sv
hw/rtl/texel_convert_mipmap_cascade_top.sv
hw/rtl/tcm_checker.sv
tb/tcm_checker.sv
tb/testbench.sv
